// ===== rtl/twes_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twes_pkg: shared types and constants of the timing wheel scheduler
// status codes, controller states and the command/status bundles between
// the controller and the datapath
// ----------------------------------------------------------------------------
package twes_pkg;

  // fixed field widths of the channels
  localparam int TIME_W   = 32;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 3;

  // defaults for the top level parameters
  localparam int DEF_SLOTS        = 64;
  localparam int DEF_POOL_ENTRIES = 64;
  localparam int DEF_TAG_BITS     = 16;

  // action codes on the input channel
  localparam logic ACT_SCHEDULE = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_SCHEDULED = 3'd0,
    ST_WINDOW    = 3'd1,
    ST_POOL      = 3'd2,
    ST_FIRED     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCHED,
    S_RESP,
    S_HEAD,
    S_WALK
  } fsm_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr;         // clear one slot head during the post-reset sweep
    logic acc;         // input transaction taken
    logic commit;      // link the new entry into its slot, report scheduled
    logic resp;        // report a rejected schedule
    logic empty;       // report an empty slot and advance time
    logic walk_begin;  // start walking the slot list
    logic walk_step;   // report one fired event and free its entry
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;    // sweep is on its final slot
    logic sched_bad;   // offered time lies outside the window
    logic pool_empty;  // no free entry and bump allocator used up
    logic head_nil;    // slot read on tick holds no events
    logic walk_last;   // event now on hand is the final one of the slot
    logic out_free;    // output register can take a result this cycle
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/twes_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twes_ctrl: controller of the timing wheel scheduler
// sequences the clearing sweep, scheduling and the slot walk on a tick
// ----------------------------------------------------------------------------
module twes_ctrl
  import twes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_action,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  fsm_state_t state_r, state_nxt;
  logic       acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (in_action == ACT_TICK) begin
            state_nxt = S_HEAD;
          end else if (stat.sched_bad || stat.pool_empty) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCHED;
          end
        end
      end
      S_SCHED, S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_HEAD: begin
        if (!stat.head_nil) begin
          state_nxt = S_WALK;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat.out_free && stat.walk_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE:  cmd.acc = acc;
      S_SCHED: cmd.commit = stat.out_free;
      S_RESP:  cmd.resp = stat.out_free;
      S_HEAD: begin
        cmd.walk_begin = !stat.head_nil;
        cmd.empty      = stat.head_nil && stat.out_free;
      end
      S_WALK:  cmd.walk_step = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/twes_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twes_dp: datapath of the timing wheel scheduler
// slot head, link and tag memories, free list, bump allocator, time keeping
// and the output register
// ----------------------------------------------------------------------------
module twes_dp
  import twes_pkg::*;
#(
  parameter int SLOTS        = DEF_SLOTS,
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
  parameter int TAG_BITS     = DEF_TAG_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic              in_action,
  input  wire logic [TIME_W-1:0] in_event_time,
  input  wire logic [TAG_W-1:0]  in_event_tag,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STATUS_W-1:0]    out_status,
  output logic [TAG_W-1:0]       out_fired_tag,
  output logic [TIME_W-1:0]      out_time_now,
  output logic                   out_last
);

  localparam int SW = $clog2(SLOTS);
  localparam int EW = $clog2(POOL_ENTRIES);
  localparam int PW = $clog2(POOL_ENTRIES + 1);
  localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

  // memories
  logic [PW-1:0] slot_head_mem [SLOTS];
  logic [PW-1:0] link_mem      [POOL_ENTRIES];
  logic [TW-1:0] tag_mem       [POOL_ENTRIES];

  // state
  logic [TIME_W-1:0] cur_time_r;
  logic [SW-1:0]     cur_slot_r;
  logic [PW-1:0]     free_head_r;
  logic [PW-1:0]     alloc_r;
  logic [SW-1:0]     clr_cnt_r;

  // per item registers
  logic [PW-1:0] head_rd_r;
  logic [PW-1:0] link_rd_r;
  logic [TW-1:0] tag_rd_r;
  logic [PW-1:0] entry_r;
  logic          from_free_r;
  logic [SW-1:0] target_r;
  logic [TW-1:0] tag_r;
  status_t       resp_code_r;
  logic [PW-1:0] cur_e_r;
  logic [EW-1:0] walk_cnt_r;

  // output register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [TAG_W-1:0]    out_tag_r;
  logic [TIME_W-1:0]   out_time_r;
  logic                out_last_r;

  // window test and target slot
  logic [TIME_W-1:0] delta;
  logic [SW:0]       slot_sum;
  logic [SW-1:0]     target;
  logic              free_avail;
  logic              bump_avail;
  logic              walk_last;
  logic              emit;
  logic              advance;

  assign delta      = in_event_time - cur_time_r;
  assign slot_sum   = (SW+1)'(cur_slot_r) + (SW+1)'(delta[SW-1:0]);
  assign target     = (slot_sum >= (SW+1)'(SLOTS)) ? SW'(slot_sum - (SW+1)'(SLOTS))
                                                   : slot_sum[SW-1:0];
  assign free_avail = (free_head_r != NIL);
  assign bump_avail = (alloc_r < NIL);
  assign walk_last  = (link_rd_r == NIL) || (walk_cnt_r == EW'(POOL_ENTRIES - 1));

  assign stat.clr_done   = (clr_cnt_r == SW'(SLOTS - 1));
  assign stat.sched_bad  = (delta == '0) || (delta >= TIME_W'(SLOTS));
  assign stat.pool_empty = !free_avail && !bump_avail;
  assign stat.head_nil   = (head_rd_r == NIL);
  assign stat.walk_last  = walk_last;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign emit    = cmd.commit || cmd.resp || cmd.empty || cmd.walk_step;
  assign advance = cmd.empty || (cmd.walk_step && walk_last);

  // slot head memory: one write, one read port
  logic          sh_we;
  logic [SW-1:0] sh_wa;
  logic [PW-1:0] sh_wd;
  logic [SW-1:0] sh_ra;

  always_comb begin
    sh_we = 1'b0;
    sh_wa = cur_slot_r;
    sh_wd = NIL;
    if (cmd.clr) begin
      sh_we = 1'b1;
      sh_wa = clr_cnt_r;
    end else if (cmd.acc && in_action == ACT_TICK) begin
      sh_we = 1'b1;
    end else if (cmd.commit) begin
      sh_we = 1'b1;
      sh_wa = target_r;
      sh_wd = entry_r;
    end
  end

  assign sh_ra = (in_action == ACT_TICK) ? cur_slot_r : target;

  always_ff @(posedge clk) begin
    if (sh_we) slot_head_mem[sh_wa] <= sh_wd;
    if (cmd.acc) head_rd_r <= slot_head_mem[sh_ra];
  end

  // link and tag memories
  logic          lk_we;
  logic [EW-1:0] lk_wa;
  logic [PW-1:0] lk_wd;
  logic          lk_re;
  logic          tg_re;
  logic [EW-1:0] rd_a;

  always_comb begin
    lk_we = cmd.commit || cmd.walk_step;
    lk_wa = cmd.commit ? entry_r[EW-1:0] : cur_e_r[EW-1:0];
    lk_wd = cmd.commit ? head_rd_r : free_head_r;
    tg_re = cmd.walk_begin || (cmd.walk_step && !walk_last);
    lk_re = tg_re || (cmd.acc && in_action == ACT_SCHEDULE && free_avail);
    if (cmd.walk_begin) begin
      rd_a = head_rd_r[EW-1:0];
    end else if (cmd.walk_step) begin
      rd_a = link_rd_r[EW-1:0];
    end else begin
      rd_a = free_head_r[EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    if (lk_re) link_rd_r <= link_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) tag_mem[entry_r[EW-1:0]] <= tag_r;
    if (tg_re) tag_rd_r <= tag_mem[rd_a];
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      entry_r     <= free_avail ? free_head_r : alloc_r;
      from_free_r <= free_avail;
      target_r    <= target;
      tag_r       <= in_event_tag[TW-1:0];
      resp_code_r <= stat.sched_bad ? ST_WINDOW : ST_POOL;
    end
    if (cmd.walk_begin) begin
      cur_e_r    <= head_rd_r;
      walk_cnt_r <= '0;
    end else if (cmd.walk_step) begin
      cur_e_r    <= link_rd_r;
      walk_cnt_r <= walk_cnt_r + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_time_r  <= '0;
      cur_slot_r  <= '0;
      free_head_r <= NIL;
      alloc_r     <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.commit) begin
        if (from_free_r) begin
          free_head_r <= link_rd_r;
        end else begin
          alloc_r <= alloc_r + 1'b1;
        end
      end else if (cmd.walk_step) begin
        free_head_r <= cur_e_r;
      end
      if (advance) begin
        cur_time_r <= cur_time_r + 1'b1;
        cur_slot_r <= (cur_slot_r == SW'(SLOTS - 1)) ? '0 : cur_slot_r + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_time_r <= cur_time_r;
      out_tag_r  <= '0;
      out_last_r <= 1'b1;
      if (cmd.commit) begin
        out_status_r <= ST_SCHEDULED;
      end else if (cmd.resp) begin
        out_status_r <= resp_code_r;
      end else if (cmd.empty) begin
        out_status_r <= ST_EMPTY;
      end else begin
        out_status_r <= ST_FIRED;
        out_tag_r    <= TAG_W'(tag_rd_r);
        out_last_r   <= walk_last;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_fired_tag = out_tag_r;
  assign out_time_now  = out_time_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/timing_wheel_event_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timing_wheel_event_scheduler: single-level timing wheel
// schedule transactions push a tag onto the slot list for its firing tick,
// tick transactions drain the current slot newest first and advance time
// ----------------------------------------------------------------------------
//  channel   ports                                          direction
//  input     in_valid in_ready in_action in_event_time      in
//            in_event_tag
//  result    out_valid out_ready out_status out_fired_tag   out
//            out_time_now out_last
//
//  steps: a schedule transaction reads the slot head and free list, then
//  does the linking write; a tick reads the slot head, then reports an empty
//  slot or walks its events, one event per cycle through the link memory port
//  while out_ready does not stall the output register; reset: after rst_n the
//  slot head memory is swept to empty, during which in_ready stays low
//  stalls: results leave through one output register; a held out_ready
//  freezes the controller in the state that owes the next result
// ----------------------------------------------------------------------------
module timing_wheel_event_scheduler
  import twes_pkg::*;
#(
  parameter int SLOTS        = DEF_SLOTS,
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
  parameter int TAG_BITS     = DEF_TAG_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_action,
  input  wire logic [TIME_W-1:0] in_event_time,
  input  wire logic [TAG_W-1:0]  in_event_tag,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STATUS_W-1:0]    out_status,
  output logic [TAG_W-1:0]       out_fired_tag,
  output logic [TIME_W-1:0]      out_time_now,
  output logic                   out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: decides which datapath step runs each cycle
  twes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: memories, free list, time keeping and result register
  twes_dp #(
    .SLOTS        (SLOTS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .TAG_BITS     (TAG_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_action     (in_action),
    .in_event_time (in_event_time),
    .in_event_tag  (in_event_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_fired_tag (out_fired_tag),
    .out_time_now  (out_time_now),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ===== tb/sv/timing_wheel_event_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timing_wheel_event_scheduler_tb: self-checking bench for the timing wheel
// requests are queued up front and driven with random gaps, results are taken
// under random back-pressure and compared field by field with a behavioural
// wheel that is updated as each input transaction is accepted
// ----------------------------------------------------------------------------
module timing_wheel_event_scheduler_tb;
  import twes_pkg::*;

  localparam int SLOTS        = DEF_SLOTS;
  localparam int POOL_ENTRIES = DEF_POOL_ENTRIES;
  localparam int TAG_BITS     = DEF_TAG_BITS;
  localparam int NIL          = POOL_ENTRIES;   // null pool index
  localparam logic [TAG_W-1:0] TAG_KEEP =
    (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} : TAG_W'((1 << TAG_BITS) - 1);

  localparam int RANDOM_ITEMS   = 77;
  localparam int DRAIN_CYCLES   = 16;     // settle time once nothing is owed
  // worst quiet spell: clearing sweep after reset, then the longest sender gap
  // or receiver stall, taken several times over
  localparam int WATCHDOG_LIMIT = 2000;

  // one queued input transaction
  typedef struct {
    logic              action;
    logic [TIME_W-1:0] fire_at;
    logic [TAG_W-1:0]  tag;
    bit                hold;      // wait until every owed result is back
  } wheel_request_t;

  // one owed result transaction
  typedef struct {
    status_t           status;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
    logic              last;
  } wheel_result_t;

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid      = 1'b0;
  logic              in_action     = ACT_SCHEDULE;
  logic [TIME_W-1:0] in_event_time = '0;
  logic [TAG_W-1:0]  in_event_tag  = '0;
  logic              out_ready     = 1'b0;

  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [TAG_W-1:0]    out_fired_tag;
  logic [TIME_W-1:0]   out_time_now;
  logic                out_last;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  timing_wheel_event_scheduler #(
    .SLOTS        (SLOTS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .TAG_BITS     (TAG_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_event_time (in_event_time),
    .in_event_tag  (in_event_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_fired_tag (out_fired_tag),
    .out_time_now  (out_time_now),
    .out_last      (out_last)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  wheel_request_t event_requests[$];   // input transactions still to drive
  wheel_result_t  due_results[$];      // results owed by the block, oldest first

  // behavioural copy of the wheel
  int                wheel_head[SLOTS];
  int                link_mem[POOL_ENTRIES];
  logic [TAG_W-1:0]  tag_mem[POOL_ENTRIES];
  int                free_top;
  int                bump_cnt;
  logic [TIME_W-1:0] wheel_time;
  int                wheel_slot;

  logic [TIME_W-1:0] plan_time = '0;   // wheel time as seen by the stimulus plan

  int             mismatches  = 0;
  int             idle_cycles = 0;
  int             quiet_left  = 0;     // cycles left in a stretch with no idling
  int             gap_left    = 0;
  int             stall_left  = 0;
  bit             in_taken    = 1'b0;  // set at the edge that accepts an input
  logic           drv_valid;
  wheel_request_t launch;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void owe_result(status_t st, logic [TAG_W-1:0] tag, logic last);
    wheel_result_t r;
    r.status = st;
    r.tag    = tag;
    r.stamp  = wheel_time;
    r.last   = last;
    due_results.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // wheel behaviour: work out the results of one accepted transaction and
  // update the bench's copy of the wheel
  // --------------------------------------------------------------------------
  task automatic advance_wheel(input logic act, input logic [TIME_W-1:0] fire_at,
                               input logic [TAG_W-1:0] tag);
    logic [TIME_W-1:0] delta;
    int entry, slot, e, nx, n;
    if (act == ACT_SCHEDULE) begin
      // distance is taken modulo 2^32, so times behind us look far ahead
      delta = fire_at - wheel_time;
      if (delta == 0 || delta >= SLOTS) begin
        owe_result(ST_WINDOW, '0, 1'b1);
      end else if (free_top == NIL && bump_cnt >= POOL_ENTRIES) begin
        owe_result(ST_POOL, '0, 1'b1);
      end else begin
        if (free_top != NIL) begin
          entry    = free_top;
          free_top = link_mem[entry];
        end else begin
          entry    = bump_cnt;
          bump_cnt = bump_cnt + 1;
        end
        slot             = (wheel_slot + int'(delta)) % SLOTS;
        tag_mem[entry]   = tag & TAG_KEEP;
        link_mem[entry]  = wheel_head[slot];
        wheel_head[slot] = entry;
        owe_result(ST_SCHEDULED, '0, 1'b1);
      end
    end else begin
      // drain the current slot newest first, handing entries back to the free list
      slot             = wheel_slot;
      e                = wheel_head[slot];
      wheel_head[slot] = NIL;
      n                = 0;
      while (e != NIL && n < POOL_ENTRIES) begin
        nx          = link_mem[e];
        owe_result(ST_FIRED, tag_mem[e], 1'b0);
        n           = n + 1;
        link_mem[e] = free_top;
        free_top    = e;
        e           = nx;
      end
      if (n == 0)
        owe_result(ST_EMPTY, '0, 1'b1);
      else
        due_results[due_results.size()-1].last = 1'b1;
      wheel_time = wheel_time + 1;
      wheel_slot = (slot + 1) % SLOTS;
    end
  endtask

  // compare one accepted result with the oldest one owed
  task automatic check_result();
    wheel_result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, got status %0d tag %h time %0d last %b",
               $time, out_status, out_fired_tag, out_time_now, out_last);
      mismatches++;
    end else begin
      want = due_results.pop_front();
      if (out_status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, out_status);
        mismatches++;
      end
      if (out_fired_tag !== want.tag) begin
        $display("%0t: fired_tag mismatch: expected %h, got %h", $time, want.tag, out_fired_tag);
        mismatches++;
      end
      if (out_time_now !== want.stamp) begin
        $display("%0t: time_now mismatch: expected %0d, got %0d", $time, want.stamp,
                 out_time_now);
        mismatches++;
      end
      if (out_last !== want.last) begin
        $display("%0t: last mismatch: expected %b, got %b", $time, want.last, out_last);
        mismatches++;
      end
    end
  endtask

  // queue a request; delta is the offset of the firing time from the planned
  // wheel time, which only ticks move on
  task automatic plan_request(input logic act, input logic [TIME_W-1:0] delta,
                              input logic [TAG_W-1:0] tag, input bit hold);
    wheel_request_t req;
    req.action  = act;
    req.fire_at = plan_time + delta;
    req.tag     = tag;
    req.hold    = hold;
    event_requests.push_back(req);
    if (act == ACT_TICK) plan_time = plan_time + 1;
  endtask

  // --------------------------------------------------------------------------
  // monitor: everything is sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        advance_wheel(in_action, in_event_time, in_event_tag);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) check_result();

      // stretches where neither side idles
      if (quiet_left > 0)
        quiet_left--;
      else if ($urandom_range(0, 199) == 0)
        quiet_left = $urandom_range(30, 120);
    end

    // watchdog on cycles with no transaction on either channel
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still owed", $time, due_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver: inputs change at the falling edge, valid holds until accepted
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drv_valid = in_valid;
      if (in_taken) begin
        in_taken  = 1'b0;
        drv_valid = 1'b0;
        gap_left  = (quiet_left > 0) ? 0 : pick_gap();
      end
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (event_requests.size() > 0 &&
                     !(event_requests[0].hold && due_results.size() > 0)) begin
          launch = event_requests.pop_front();
          in_action     <= launch.action;
          in_event_time <= launch.fire_at;
          in_event_tag  <= launch.tag;
          drv_valid     = 1'b1;
        end
      end
      in_valid <= drv_valid;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0 && quiet_left == 0 && $urandom_range(0, 99) < 20)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus plan, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int roll;
    logic [TIME_W-1:0] delta;

    for (int i = 0; i < SLOTS; i++) wheel_head[i] = NIL;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      link_mem[i] = 0;
      tag_mem[i]  = '0;
    end
    free_top   = NIL;
    bump_cnt   = 0;
    wheel_time = '0;
    wheel_slot = 0;

    // directed: empty slot and the edges of the scheduling window
    plan_request(ACT_TICK,     32'd0,                   16'hFFFF, 1'b0);
    plan_request(ACT_SCHEDULE, 32'd0,                   16'h1111, 1'b0);  // distance zero
    plan_request(ACT_SCHEDULE, SLOTS,                   16'h2222, 1'b0);  // one past window
    plan_request(ACT_SCHEDULE, 32'hFFFF_FFFF,           16'hFFFF, 1'b0);  // one tick behind
    plan_request(ACT_SCHEDULE, 32'd0 - plan_time,       16'h0000, 1'b0);  // absolute time 0
    plan_request(ACT_SCHEDULE, 32'hFFFF_FFFF - plan_time, 16'hABCD, 1'b0); // all ones time
    plan_request(ACT_TICK,     32'hFFFF_FFFF,           16'h0000, 1'b0);

    // fill the whole pool into one slot after a full drain, overflow it twice,
    // then fire the lot in a single tick
    for (int i = 0; i < POOL_ENTRIES + 2; i++)
      plan_request(ACT_SCHEDULE, 32'd1, TAG_W'($urandom_range(0, 16'hFFFF)), i == 0);
    plan_request(ACT_TICK, 32'd0, 16'h0000, 1'b0);
    plan_request(ACT_TICK, 32'd0, 16'h0000, 1'b0);

    // newest-first order, far edge of the window and free list reuse
    plan_request(ACT_SCHEDULE, 32'd1,       16'h0000, 1'b0);
    plan_request(ACT_SCHEDULE, 32'd1,       16'hFFFF, 1'b0);
    plan_request(ACT_SCHEDULE, 32'd2,       16'h1234, 1'b0);
    plan_request(ACT_SCHEDULE, SLOTS - 1,   16'h8001, 1'b0);
    plan_request(ACT_TICK,     32'd5,       16'h5555, 1'b0);
    plan_request(ACT_TICK,     32'd0,       16'hAAAA, 1'b0);
    plan_request(ACT_TICK,     32'd0,       16'h0000, 1'b0);
    plan_request(ACT_SCHEDULE, SLOTS,       16'h7FFF, 1'b0);

    // random part: mostly in-window schedules and ticks, some rejects
    repeat (RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        delta = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(1, SLOTS - 1);
        plan_request(ACT_SCHEDULE, delta, TAG_W'($urandom_range(0, 16'hFFFF)),
                     $urandom_range(0, 99) < 3);
      end else if (roll < 60) begin
        case ($urandom_range(0, 2))
          0:       delta = 32'd0;
          1:       delta = $urandom_range(SLOTS, 4 * SLOTS);
          default: delta = $urandom();
        endcase
        plan_request(ACT_SCHEDULE, delta, TAG_W'($urandom_range(0, 16'hFFFF)), 1'b0);
      end else begin
        // ticks carry junk in the fields they ignore
        plan_request(ACT_TICK, $urandom(), TAG_W'($urandom_range(0, 16'hFFFF)),
                     $urandom_range(0, 99) < 3);
      end
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (event_requests.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/twes_pkg.sv
rtl/twes_ctrl.sv
rtl/twes_dp.sv
rtl/timing_wheel_event_scheduler.sv
tb/sv/timing_wheel_event_scheduler_tb.sv
